[sv/fdr_pkg.sv]
// Shared types and constants for the feature delta regression block.
// Used by the front, queue, back and top-level modules; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fdr_pkg;

  // Field widths fixed by the stream format
  localparam int COEFF_W  = 16;
  localparam int SLOT_W   = 4;
  localparam int CFG_W    = 5;
  localparam int FRAMES_W = 3;

  // Reset value of the frame size register
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd13;

  // Entries in the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // One classified input transaction, as handed from front to back
  typedef struct packed {
    logic signed [COEFF_W-1:0] value;     // incoming coefficient
    logic [SLOT_W-1:0]         slot;      // slot the coefficient is stored in
    logic [CFG_W-1:0]          cnt;       // clamped frame size
    logic [FRAMES_W-1:0]       f_before;  // completed frames before this one
    logic [FRAMES_W-1:0]       f_after;   // completed frames after this one
    logic                      regular;   // a regular delta leaves
    logic                      flush;     // end of utterance: flush last frames
  } fdr_cmd_t;

endpackage

`default_nettype wire

[sv/fdr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fdr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[sv/fdr_front.sv]
// Front end: holds the frame size register, tracks slot and frame counts,
// and classifies each input transaction into a command. Uses fdr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdr_front #(
  parameter int HALF_WINDOW = 2,
  parameter int MAX_COEFFS  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [fdr_pkg::CFG_W-1:0]         cfg_wr_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [fdr_pkg::COEFF_W-1:0] in_coeff_value,
  input  wire logic                              in_utterance_end,
  input  wire logic                              q_full,
  output logic                                   push,
  output fdr_pkg::fdr_cmd_t                      push_cmd
);

  logic [fdr_pkg::CFG_W-1:0]    cfg_r, cfg_nxt;
  logic [fdr_pkg::SLOT_W-1:0]   slot_r, slot_nxt;
  logic [fdr_pkg::FRAMES_W-1:0] frames_r, frames_nxt;

  logic [fdr_pkg::CFG_W-1:0]    cnt;
  logic [fdr_pkg::SLOT_W-1:0]   slot_eff;
  logic                         frame_end;
  logic [fdr_pkg::FRAMES_W-1:0] frames_after;
  logic                         flush;

  // Clamp the frame size into 1..MAX_COEFFS
  always_comb begin
    if (cfg_r == '0) begin
      cnt = fdr_pkg::CFG_W'(1);
    end else if (cfg_r > fdr_pkg::CFG_W'(MAX_COEFFS)) begin
      cnt = fdr_pkg::CFG_W'(MAX_COEFFS);
    end else begin
      cnt = cfg_r;
    end
  end

  // Classify the incoming transaction
  always_comb begin
    if ({1'b0, slot_r} >= cnt) begin
      slot_eff = fdr_pkg::SLOT_W'(cnt - fdr_pkg::CFG_W'(1));
    end else begin
      slot_eff = slot_r;
    end
    frame_end = ({1'b0, slot_eff} == (cnt - fdr_pkg::CFG_W'(1)));
    if (frame_end && (frames_r < fdr_pkg::FRAMES_W'(2 * HALF_WINDOW))) begin
      frames_after = frames_r + fdr_pkg::FRAMES_W'(1);
    end else begin
      frames_after = frames_r;
    end
    flush = frame_end && in_utterance_end;
  end

  // Hand the command to the queue when there is room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_cmd.value    = in_coeff_value;
    push_cmd.slot     = slot_eff;
    push_cmd.cnt      = cnt;
    push_cmd.f_before = frames_r;
    push_cmd.f_after  = frames_after;
    push_cmd.regular  = (frames_r >= fdr_pkg::FRAMES_W'(HALF_WINDOW));
    push_cmd.flush    = flush;
  end

  // Advance slot and frame counters on each accepted transaction
  always_comb begin
    cfg_nxt    = cfg_wr_en ? cfg_wr_data : cfg_r;
    slot_nxt   = slot_r;
    frames_nxt = frames_r;
    if (push) begin
      slot_nxt   = frame_end ? '0 : slot_eff + fdr_pkg::SLOT_W'(1);
      frames_nxt = flush ? '0 : frames_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r    <= fdr_pkg::CFG_RESET;
      slot_r   <= '0;
      frames_r <= '0;
    end else begin
      cfg_r    <= cfg_nxt;
      slot_r   <= slot_nxt;
      frames_r <= frames_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/fdr_queue.sv]
// Short command queue between the front end and the back end.
// Uses fdr_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module fdr_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire fdr_pkg::fdr_cmd_t push_cmd,
  input  wire logic              pop,
  output fdr_pkg::fdr_cmd_t      head,
  output logic                   full,
  output logic                   empty
);

  localparam int PW = (fdr_pkg::QUEUE_DEPTH > 1) ? $clog2(fdr_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(fdr_pkg::QUEUE_DEPTH + 1);

  fdr_pkg::fdr_cmd_t entry_r [fdr_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CW'(fdr_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(fdr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(fdr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

[sv/fdr_back.sv]
// Back end: sequencer that reads the frame history, shifts in new values,
// forms each delta and divides it, and drives the output register.
// Uses fdr_pkg and one fdr_ram for the history.
`timescale 1ns / 1ps
`default_nettype none

module fdr_back #(
  parameter int HALF_WINDOW = 2,
  parameter int MAX_COEFFS  = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire fdr_pkg::fdr_cmd_t                  head,
  input  wire logic                               empty,
  output logic                                    pop,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [fdr_pkg::COEFF_W-1:0]      out_delta_value,
  output logic [fdr_pkg::SLOT_W-1:0]              out_coeff_slot,
  output logic                                    out_run_last
);

  localparam int CW    = fdr_pkg::COEFF_W;
  localparam int NTAP  = 2 * HALF_WINDOW;
  localparam int RW    = CW * NTAP;
  localparam int AW    = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
  localparam int JW    = (HALF_WINDOW > 1) ? $clog2(HALF_WINDOW) : 1;
  localparam int NEXT  = 3 * HALF_WINDOW + 1;
  localparam int PW    = $clog2(NEXT);
  localparam int SW    = CW + 1 + $clog2(HALF_WINDOW * (HALF_WINDOW + 1) / 2 + 1);
  localparam int MW    = SW - 1;
  localparam int DENOM = HALF_WINDOW * (HALF_WINDOW + 1) * (2 * HALF_WINDOW + 1) / 3;
  localparam int RECIP = (1 << MW) / DENOM;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]                       state_r, state_nxt;
  fdr_pkg::fdr_cmd_t                cmd_r, cmd_nxt;
  logic                             phase_reg_r, phase_reg_nxt;
  logic [JW-1:0]                    j_r, j_nxt;
  logic [fdr_pkg::SLOT_W-1:0]       i_r, i_nxt;
  logic signed [SW-1:0]             sum_r, sum_nxt;
  logic [MW-1:0]                    mag_r, mag_nxt;
  logic                             neg_r, neg_nxt;
  logic [2*MW-1:0]                  prod_r, prod_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic signed [CW-1:0]             out_value_r, out_value_nxt;
  logic [fdr_pkg::SLOT_W-1:0]       out_slot_r, out_slot_nxt;
  logic                             out_last_r, out_last_nxt;

  logic                             ram_we;
  logic [AW-1:0]                    ram_raddr;
  logic [RW-1:0]                    ram_wdata;
  logic [RW-1:0]                    ram_rdata;

  logic [JW-1:0]                    j_sel;
  logic [JW-1:0]                    j_start;
  logic [fdr_pkg::FRAMES_W-1:0]     f_sel;
  logic signed [CW-1:0]             extp [NEXT];
  logic [PW-1:0]                    pa, pb;
  logic signed [SW-1:0]             acc;
  logic [MW-1:0]                    q0, qd, rem, q;
  logic [fdr_pkg::SLOT_W-1:0]       cur_slot;
  logic                             i_last;
  logic                             is_last;
  logic                             out_load;

  // Frame history: one row per slot, all taps of that slot side by side
  fdr_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_COEFFS)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd_r.slot[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Current slot, window position and frame count in use
  assign cur_slot  = phase_reg_r ? cmd_r.slot : i_r;
  assign ram_raddr = cur_slot[AW-1:0];
  assign j_sel     = phase_reg_r ? JW'(HALF_WINDOW - 1) : j_r;
  assign f_sel     = phase_reg_r ? cmd_r.f_before : cmd_r.f_after;
  assign ram_we    = (state_r == ST_SUM) && phase_reg_r;
  assign ram_wdata = (NTAP > 1) ? {ram_rdata[RW-CW-1:0], cmd_r.value} : RW'(cmd_r.value);

  // First flush row: newest frame that still has HALF_WINDOW frames of history
  always_comb begin
    if (cmd_r.f_after >= fdr_pkg::FRAMES_W'(HALF_WINDOW)) begin
      j_start = JW'(HALF_WINDOW - 1);
    end else begin
      j_start = JW'(cmd_r.f_after - fdr_pkg::FRAMES_W'(1));
    end
  end

  assign i_last  = ({1'b0, i_r} == (cmd_r.cnt - fdr_pkg::CFG_W'(1)));
  assign is_last = phase_reg_r ? !cmd_r.flush : ((j_r == '0) && i_last);

  // Build the zero-padded window and the weighted difference sum
  always_comb begin
    for (int p = 0; p < NEXT; p++) begin
      if (p < HALF_WINDOW) begin
        extp[p] = '0;
      end else if (p == HALF_WINDOW) begin
        extp[p] = phase_reg_r ? cmd_r.value : '0;
      end else if (fdr_pkg::FRAMES_W'(p - HALF_WINDOW - 1) < f_sel) begin
        extp[p] = $signed(ram_rdata[CW*(p-HALF_WINDOW-1) +: CW]);
      end else begin
        extp[p] = '0;
      end
    end
    acc = '0;
    pa  = '0;
    pb  = '0;
    for (int n = 1; n <= HALF_WINDOW; n++) begin
      pa  = PW'(j_sel) + PW'(HALF_WINDOW + 1 - n);
      pb  = PW'(j_sel) + PW'(HALF_WINDOW + 1 + n);
      acc = acc + SW'(n) * (SW'(extp[pa]) - SW'(extp[pb]));
    end
  end

  // Divide by the constant denominator: reciprocal multiply, then one fix-up
  always_comb begin
    q0  = prod_r[2*MW-1:MW];
    qd  = MW'(q0 * MW'(DENOM));
    rem = mag_r - qd;
    q   = (rem >= MW'(DENOM)) ? q0 + MW'(1) : q0;
  end

  assign out_load = !out_valid_r || !out_stall;
  assign pop      = (state_r == ST_IDLE) && !empty;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    phase_reg_nxt = phase_reg_r;
    j_nxt         = j_r;
    i_nxt         = i_r;
    sum_nxt       = sum_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    out_value_nxt = out_value_r;
    out_slot_nxt  = out_slot_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    case (state_r)
      ST_IDLE: begin
        // Every command first shifts its value into the history row
        if (!empty) begin
          cmd_nxt       = head;
          phase_reg_nxt = 1'b1;
          state_nxt     = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        sum_nxt = acc;
        if (phase_reg_r && !cmd_r.regular) begin
          // No regular result: history is updated, go flush or finish
          if (cmd_r.flush) begin
            phase_reg_nxt = 1'b0;
            i_nxt         = '0;
            j_nxt         = j_start;
            state_nxt     = ST_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        neg_nxt   = sum_r[SW-1];
        mag_nxt   = sum_r[SW-1] ? MW'(-sum_r) : MW'(sum_r);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // mag_r is settled here; product is registered for the fix-up
        prod_nxt  = (2*MW)'(mag_r) * (2*MW)'(RECIP);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = neg_r ? -CW'(q) : CW'(q);
          out_slot_nxt  = cur_slot;
          out_last_nxt  = is_last;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else if (phase_reg_r) begin
            phase_reg_nxt = 1'b0;
            i_nxt         = '0;
            j_nxt         = j_start;
            state_nxt     = ST_RD;
          end else begin
            if (i_last) begin
              i_nxt = '0;
              j_nxt = j_r - JW'(1);
            end else begin
              i_nxt = i_r + fdr_pkg::SLOT_W'(1);
            end
            state_nxt = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and command registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    phase_reg_r <= phase_reg_nxt;
    j_r         <= j_nxt;
    i_r         <= i_nxt;
    sum_r       <= sum_nxt;
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    prod_r      <= prod_nxt;
    out_value_r <= out_value_nxt;
    out_slot_r  <= out_slot_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_delta_value = out_value_r;
  assign out_coeff_slot  = out_slot_r;
  assign out_run_last    = out_last_r;

endmodule

`default_nettype wire

[sv/feature_delta_regression.sv]
// Delta regression over a stream of feature frames: the top level.
// Instantiates fdr_front, fdr_queue and fdr_back; uses fdr_pkg.
//   Input transactions carry one signed Q8.8 coefficient, frame-major, plus
//   an end mark on the last coefficient of the utterance. The result for
//   slot i of frame t leaves with slot i of frame t+HALF_WINDOW; the end mark
//   also flushes up to HALF_WINDOW final frames, one result per slot per
//   frame, with run_last high on the final result of each transaction.
//   cfg_wr_en/cfg_wr_data set coefficients per frame (reset 13); write it
//   only while the block is idle.
// Sequencing:
//   The back end pops a command only while idle and finishes it first;
//   each result steps through history read, sum, magnitude, reciprocal
//   multiply, fix-up and output load. A transaction with no result still
//   rewrites its history row and returns to idle after the sum. A flush of
//   F frames of C slots repeats the result steps once per slot per frame. A
//   2-entry command queue lets the front keep accepting while the back works.
// Reset and stall:
//   rst_n (synchronous, active low) clears counters, queue and output valid;
//   history is masked by the frame count. While out_stall is high the output
//   holds, the back end waits, and once the queue is full in_stall rises.

`timescale 1ns / 1ps
`default_nettype none

module feature_delta_regression #(
  parameter int HALF_WINDOW = 2,
  parameter int MAX_COEFFS  = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [fdr_pkg::CFG_W-1:0]          cfg_wr_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [fdr_pkg::COEFF_W-1:0] in_coeff_value,
  input  wire logic                               in_utterance_end,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [fdr_pkg::COEFF_W-1:0]      out_delta_value,
  output logic [fdr_pkg::SLOT_W-1:0]              out_coeff_slot,
  output logic                                    out_run_last
);

  fdr_pkg::fdr_cmd_t push_cmd;
  fdr_pkg::fdr_cmd_t head;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;

  // Accept and classify
  fdr_front #(
    .HALF_WINDOW (HALF_WINDOW),
    .MAX_COEFFS  (MAX_COEFFS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_coeff_value   (in_coeff_value),
    .in_utterance_end (in_utterance_end),
    .q_full           (q_full),
    .push             (push),
    .push_cmd         (push_cmd)
  );

  // Decouple front and back
  fdr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Compute and deliver results
  fdr_back #(
    .HALF_WINDOW (HALF_WINDOW),
    .MAX_COEFFS  (MAX_COEFFS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .empty           (q_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_delta_value (out_delta_value),
    .out_coeff_slot  (out_coeff_slot),
    .out_run_last    (out_run_last)
  );

endmodule

`default_nettype wire

[sv/fdr_checker.sv]
// Port-level checks for feature_delta_regression, attached by bind.
// Sees only the top-level ports; uses fdr_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module fdr_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic signed [fdr_pkg::COEFF_W-1:0] out_delta_value,
  input wire logic [fdr_pkg::SLOT_W-1:0]         out_coeff_slot,
  input wire logic                               out_run_last
);

  // Output register is empty right after reset
  a_out_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // Command queue is empty right after reset, so input is not stalled
  a_in_open_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("in_stall high right after reset");

  // A stalled result transaction stays offered
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // A stalled result transaction keeps its payload
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_delta_value) && $stable(out_coeff_slot)
      && $stable(out_run_last))
    else $error("result payload changed while stalled");

endmodule

bind feature_delta_regression fdr_checker u_fdr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_delta_value (out_delta_value),
  .out_coeff_slot  (out_coeff_slot),
  .out_run_last    (out_run_last)
);

`default_nettype wire
